[design/fcprt_pkg.sv]
`default_nettype none

package fcprt_pkg;

  localparam int NTIMERS  = 5;
  localparam int NCOMPARE = 4;

  // bus access size that is accepted
  localparam logic [2:0] ACC_BYTES = 3'd4;

  // write masks for the config and control words
  localparam logic [23:0] CFG1_MASK = 24'hFF_FFFF;
  localparam logic [22:0] TCON_MASK = 23'h7F_FF1F;

  // largest div field whose limit 2 << div still fits in 8 bits
  localparam logic [3:0] DIV_MAX = 4'd6;

  // timers clocked by first-level prescaler A; the rest use prescaler B
  localparam logic [NTIMERS-1:0] GROUP_A = 5'h03;

  // control word bit positions per timer
  localparam logic [4:0] START_POS  [NTIMERS] = '{5'd0, 5'd8, 5'd12, 5'd16, 5'd20};
  localparam logic [4:0] MANUAL_POS [NTIMERS] = '{5'd1, 5'd9, 5'd13, 5'd17, 5'd21};
  localparam logic [4:0] RELOAD_POS [NTIMERS] = '{5'd3, 5'd11, 5'd15, 5'd19, 5'd22};

  // register word offsets
  localparam logic [4:0] ADDR_TCFG0  = 5'd0;
  localparam logic [4:0] ADDR_TCFG1  = 5'd1;
  localparam logic [4:0] ADDR_TCON   = 5'd2;
  localparam logic [4:0] ADDR_TCNTB0 = 5'd3;
  localparam logic [4:0] ADDR_TCMPB0 = 5'd4;
  localparam logic [4:0] ADDR_TCNTO0 = 5'd5;
  localparam logic [4:0] ADDR_TCNTB1 = 5'd6;
  localparam logic [4:0] ADDR_TCMPB1 = 5'd7;
  localparam logic [4:0] ADDR_TCNTO1 = 5'd8;
  localparam logic [4:0] ADDR_TCNTB2 = 5'd9;
  localparam logic [4:0] ADDR_TCMPB2 = 5'd10;
  localparam logic [4:0] ADDR_TCNTO2 = 5'd11;
  localparam logic [4:0] ADDR_TCNTB3 = 5'd12;
  localparam logic [4:0] ADDR_TCMPB3 = 5'd13;
  localparam logic [4:0] ADDR_TCNTO3 = 5'd14;
  localparam logic [4:0] ADDR_TCNTB4 = 5'd15;
  localparam logic [4:0] ADDR_TCNTO4 = 5'd16;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    W_NONE,
    W_TCFG0,
    W_TCFG1,
    W_TCON,
    W_RELOAD,
    W_COMPARE,
    W_COUNT
  } word_kind_t;

  typedef struct packed {
    word_kind_t kind;
    logic [2:0] timer;
  } word_dec_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  word_index;
    logic [2:0]  access_bytes;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_ok;
    logic [4:0]  timer_irq;
    logic [4:0]  dma_request;
  } out_item_t;

  // control bits seen by one timer channel
  typedef struct packed {
    logic start;
    logic manual;
    logic autoreload;
  } ch_ctl_t;

  // per-channel events on a divided tick
  typedef struct packed {
    logic clr_manual;
    logic clr_start;
    logic expire;
  } ch_evt_t;

  function automatic word_dec_t fcprt_decode(input logic [4:0] w);
    word_dec_t d;
    d.kind  = W_NONE;
    d.timer = 3'd0;
    unique case (w)
      ADDR_TCFG0:  d.kind = W_TCFG0;
      ADDR_TCFG1:  d.kind = W_TCFG1;
      ADDR_TCON:   d.kind = W_TCON;
      ADDR_TCNTB0: begin d.kind = W_RELOAD;  d.timer = 3'd0; end
      ADDR_TCMPB0: begin d.kind = W_COMPARE; d.timer = 3'd0; end
      ADDR_TCNTO0: begin d.kind = W_COUNT;   d.timer = 3'd0; end
      ADDR_TCNTB1: begin d.kind = W_RELOAD;  d.timer = 3'd1; end
      ADDR_TCMPB1: begin d.kind = W_COMPARE; d.timer = 3'd1; end
      ADDR_TCNTO1: begin d.kind = W_COUNT;   d.timer = 3'd1; end
      ADDR_TCNTB2: begin d.kind = W_RELOAD;  d.timer = 3'd2; end
      ADDR_TCMPB2: begin d.kind = W_COMPARE; d.timer = 3'd2; end
      ADDR_TCNTO2: begin d.kind = W_COUNT;   d.timer = 3'd2; end
      ADDR_TCNTB3: begin d.kind = W_RELOAD;  d.timer = 3'd3; end
      ADDR_TCMPB3: begin d.kind = W_COMPARE; d.timer = 3'd3; end
      ADDR_TCNTO3: begin d.kind = W_COUNT;   d.timer = 3'd3; end
      ADDR_TCNTB4: begin d.kind = W_RELOAD;  d.timer = 3'd4; end
      ADDR_TCNTO4: begin d.kind = W_COUNT;   d.timer = 3'd4; end
      default:     d.kind = W_NONE;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[design/fcprt_channel.sv]
`default_nettype none

module fcprt_channel #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     tick_en,
  input  logic [3:0]               div,
  input  fcprt_pkg::ch_ctl_t       ctl,
  input  logic [COUNTER_WIDTH-1:0] reload_value,
  output logic [COUNTER_WIDTH-1:0] count,
  output fcprt_pkg::ch_evt_t       evt
);
  import fcprt_pkg::*;

  logic [7:0]               dcnt_r, dcnt_nxt;
  logic [COUNTER_WIDTH-1:0] count_r, count_nxt, cnt_pre;
  logic [7:0]               lim;
  logic                     lim_ok, fire;

  assign lim_ok  = (div <= DIV_MAX);
  assign lim     = 8'd2 << div[2:0];
  assign fire    = tick_en && lim_ok && (dcnt_r >= lim);
  // pending manual reload happens before the countdown step
  assign cnt_pre = ctl.manual ? reload_value : count_r;

  always_comb begin
    dcnt_nxt  = dcnt_r;
    count_nxt = count_r;
    evt       = '0;
    if (tick_en) begin
      if (fire) begin
        dcnt_nxt       = 8'd0;
        evt.clr_manual = ctl.manual;
        count_nxt      = cnt_pre;
        if (ctl.start) begin
          if (cnt_pre != '0) begin
            count_nxt = cnt_pre - COUNTER_WIDTH'(1);
          end else begin
            evt.expire = 1'b1;
            if (ctl.autoreload) begin
              count_nxt = reload_value;
            end else begin
              evt.clr_start = 1'b1;
            end
          end
        end
      end else begin
        dcnt_nxt = dcnt_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r  <= 8'd0;
      count_r <= '0;
    end else begin
      dcnt_r  <= dcnt_nxt;
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

`default_nettype wire

[design/five_channel_prescaled_reload_timer_top.sv]
// A result is registered in out_r, or in the skid if out_r is full and stalled.
// Throughput: one item (tick or bus access) per cycle unless the skid is full;
//   all state updates in the accepting cycle. A two-entry buffer (output
//   register plus skid) keeps in_ready high while one result awaits out_ready.
// Reset: synchronous, active-low rst_n clears the register map and counters and
//   empties the output buffer; all readable words read zero afterwards.
`default_nettype none

module five_channel_prescaled_reload_timer_top #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fcprt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fcprt_pkg::out_item_t out_data
);
  import fcprt_pkg::*;

  localparam int CW = COUNTER_WIDTH;

  // ---------------------------------------------------------------------------
  // Register map state
  // ---------------------------------------------------------------------------
  logic [7:0]    dead_zone_r;
  logic [7:0]    pa_lim_r, pb_lim_r;
  logic [7:0]    pa_cnt_r, pb_cnt_r;
  logic [23:0]   cfg1_r;
  logic [22:0]   tcon_r, tcon_nxt;
  logic [CW-1:0] reload_r  [NTIMERS];
  logic [CW-1:0] compare_r [NCOMPARE];

  // ---------------------------------------------------------------------------
  // Item decode
  // ---------------------------------------------------------------------------
  logic      in_xfer;
  logic      is_tick, is_rd, is_wr;
  logic      acc_ok, wr_en, tick_xfer;
  word_dec_t dec;

  assign in_xfer = in_valid && in_ready;
  assign dec     = fcprt_decode(in_data.word_index);
  assign is_tick = (in_data.mode == MODE_TICK);
  assign is_rd   = (in_data.mode == MODE_READ);
  assign is_wr   = (in_data.mode == MODE_WRITE);

  // bad size, unmapped word and writes to count words are rejected
  assign acc_ok = (is_rd || is_wr) && (in_data.access_bytes == ACC_BYTES) &&
                  (dec.kind != W_NONE) && !(is_wr && dec.kind == W_COUNT);
  assign wr_en     = in_xfer && is_wr && acc_ok;
  assign tick_xfer = in_xfer && is_tick;

  // ---------------------------------------------------------------------------
  // First-level prescalers: fire when count (before increment) >= limit
  // ---------------------------------------------------------------------------
  logic pa_fire, pb_fire;

  assign pa_fire = (pa_cnt_r >= pa_lim_r);
  assign pb_fire = (pb_cnt_r >= pb_lim_r);

  // ---------------------------------------------------------------------------
  // Timer channels
  // ---------------------------------------------------------------------------
  logic [NTIMERS-1:0] tick_en;
  ch_ctl_t            ctl     [NTIMERS];
  ch_evt_t            evt     [NTIMERS];
  logic [CW-1:0]      count_w [NTIMERS];
  logic [NTIMERS-1:0] irq, dma;
  logic [3:0]         dma_sel;

  assign dma_sel = cfg1_r[23:20];

  for (genvar t = 0; t < NTIMERS; t++) begin : g_ch
    assign tick_en[t] = tick_xfer && (GROUP_A[t] ? pa_fire : pb_fire);

    assign ctl[t].start      = tcon_r[START_POS[t]];
    assign ctl[t].manual     = tcon_r[MANUAL_POS[t]];
    assign ctl[t].autoreload = tcon_r[RELOAD_POS[t]];

    fcprt_channel #(
      .COUNTER_WIDTH(CW)
    ) u_ch (
      .clk          (clk),
      .rst_n        (rst_n),
      .tick_en      (tick_en[t]),
      .div          (cfg1_r[4*t +: 4]),
      .ctl          (ctl[t]),
      .reload_value (reload_r[t]),
      .count        (count_w[t]),
      .evt          (evt[t])
    );

    // DMA select value t+1 steers this timer's expiry to the DMA flag
    assign dma[t] = evt[t].expire && (dma_sel == 4'(t + 1));
    assign irq[t] = evt[t].expire && (dma_sel != 4'(t + 1));
  end

  // control word: bus write, or self-clearing of manual/start bits on a tick
  always_comb begin
    tcon_nxt = tcon_r;
    if (wr_en && dec.kind == W_TCON) begin
      tcon_nxt = in_data.write_data[22:0] & TCON_MASK;
    end
    for (int t = 0; t < NTIMERS; t++) begin
      if (evt[t].clr_manual) tcon_nxt[MANUAL_POS[t]] = 1'b0;
      if (evt[t].clr_start)  tcon_nxt[START_POS[t]]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= 8'd0;
      pa_lim_r    <= 8'd0;
      pb_lim_r    <= 8'd0;
      pa_cnt_r    <= 8'd0;
      pb_cnt_r    <= 8'd0;
      cfg1_r      <= 24'd0;
      tcon_r      <= 23'd0;
      for (int t = 0; t < NTIMERS; t++) reload_r[t] <= '0;
      for (int c = 0; c < NCOMPARE; c++) compare_r[c] <= '0;
    end else begin
      tcon_r <= tcon_nxt;
      if (tick_xfer) begin
        pa_cnt_r <= pa_fire ? 8'd0 : pa_cnt_r + 8'd1;
        pb_cnt_r <= pb_fire ? 8'd0 : pb_cnt_r + 8'd1;
      end
      if (wr_en) begin
        case (dec.kind)
          W_TCFG0: begin
            dead_zone_r <= in_data.write_data[23:16];
            pb_lim_r    <= in_data.write_data[15:8];
            pa_lim_r    <= in_data.write_data[7:0];
          end
          W_TCFG1: cfg1_r <= in_data.write_data[23:0] & CFG1_MASK;
          W_RELOAD: begin
            for (int t = 0; t < NTIMERS; t++) begin
              if (dec.timer == 3'(t)) reload_r[t] <= in_data.write_data[CW-1:0];
            end
          end
          W_COMPARE: compare_r[dec.timer[1:0]] <= in_data.write_data[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Read mux and result
  // ---------------------------------------------------------------------------
  logic [31:0] rd_word;
  out_item_t   res;

  always_comb begin
    case (dec.kind)
      W_TCFG0:   rd_word = {8'd0, dead_zone_r, pb_lim_r, pa_lim_r};
      W_TCFG1:   rd_word = {8'd0, cfg1_r};
      W_TCON:    rd_word = {9'd0, tcon_r};
      W_RELOAD:  rd_word = 32'(reload_r[dec.timer]);
      W_COMPARE: rd_word = 32'(compare_r[dec.timer[1:0]]);
      W_COUNT:   rd_word = 32'(count_w[dec.timer]);
      default:   rd_word = 32'd0;
    endcase
  end

  // irq/dma bits can only be set on a tick, so access results carry zeros
  assign res.read_data   = (is_rd && acc_ok) ? rd_word : 32'd0;
  assign res.access_ok   = acc_ok;
  assign res.timer_irq   = irq;
  assign res.dma_request = dma;

  // ---------------------------------------------------------------------------
  // Output register plus skid stage
  // ---------------------------------------------------------------------------
  logic      out_valid_r, skid_valid_r;
  out_item_t out_r, skid_r;
  logic      pop;

  assign pop      = out_valid_r && out_ready;
  assign in_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid_r || pop) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[design/fcprt_checker.sv]
`default_nettype none

module fcprt_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire fcprt_pkg::in_item_t  in_data,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire fcprt_pkg::out_item_t out_data
);
  import fcprt_pkg::*;

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a transfer into an empty output shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("result missing one cycle after transfer");

  // accesses never carry timer events
  a_access_no_evt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.access_ok |->
      (out_data.timer_irq == 5'd0) && (out_data.dma_request == 5'd0))
    else $error("timer event on an access result");

  // an expiry goes to irq or dma, never both; read data only on accepted access
  a_evt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.timer_irq & out_data.dma_request) == 5'd0) &&
                  (out_data.access_ok || out_data.read_data == 32'd0))
    else $error("inconsistent result fields");

endmodule

bind five_channel_prescaled_reload_timer_top fcprt_checker u_fcprt_checker (.*);

`default_nettype wire
